>>> rtl/tame_pkg.sv
package tame_pkg;

    // Field widths fixed by the port list.
    localparam int RATE_W    = 16;
    localparam int ELAPSED_W = 16;
    localparam int POS_W     = 21;
    localparam int CMD_W     = 3;

    // One revolution is a power of two, so wrapping is a plain modular add.
    localparam int AZ_W          = 21;
    localparam int STEPS_PER_REV = 1 << AZ_W;

    localparam int ALT_LIMIT = 524288;

    // Product of elapsed time and slew rate.
    localparam int STEP_W    = ELAPSED_W + RATE_W;
    // Altitude count plus or minus a full step count, with a sign bit to spare.
    localparam int ALT_SUM_W = STEP_W + 2;
    // Distance between two altitude counts.
    localparam int DIST_W    = POS_W + 1;

    localparam logic [RATE_W-1:0] SLEW_RATE_RESET = RATE_W'(1024);

    localparam logic signed [POS_W-1:0]     ALT_MAX     = POS_W'(ALT_LIMIT);
    localparam logic signed [POS_W-1:0]     ALT_MIN     = -POS_W'(ALT_LIMIT);
    localparam logic signed [ALT_SUM_W-1:0] ALT_SUM_MAX = ALT_SUM_W'(ALT_LIMIT);
    localparam logic signed [ALT_SUM_W-1:0] ALT_SUM_MIN = -ALT_SUM_W'(ALT_LIMIT);

    localparam logic [AZ_W-1:0] HALF_REV = AZ_W'(STEPS_PER_REV / 2);

    localparam logic DIR_FWD = 1'b1;
    localparam logic DIR_REV = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_GOTO      = 3'd1,
        CMD_MOVE_ALT  = 3'd2,
        CMD_MOVE_AZ   = 3'd3,
        CMD_ABORT     = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_SLEW    = 2'd1,
        MODE_SLEW_TO = 2'd2
    } mode_t;

endpackage

>>> rtl/two_axis_mount_encoder_stepper_top.sv
// Two-axis mount position engine.
// Input channel (in_valid / in_stall) carries one command word: tick, goto,
// move one axis, or abort. Output channel (out_valid / out_stall) returns one
// word per command with both encoder positions, both axis modes and the goto
// busy flag as they stand after that command.
// The slew rate register is written through cfg_write / cfg_data; the user
// must write it only while the block is idle (the block does not enforce
// this). It resets to 1024 steps per time unit. The first stage registers
// the command and the product elapsed_units times slew rate; the second
// stage does the add, wrap, clamp and compare for both axes and updates
// the axis state, which is also the result register.
// Throughput is one command per cycle while the receiver takes words.
// When the receiver stalls, the result word holds, the command stage keeps
// one command waiting, and in_stall rises once that stage is full.
// Reset clears both positions and goals, stops both axes, sets both
// directions forward, clears the goto flag and empties both stages.
module two_axis_mount_encoder_stepper_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tame_pkg::RATE_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [tame_pkg::CMD_W-1:0]           cmd,
    input  logic [tame_pkg::ELAPSED_W-1:0]       elapsed_units,
    input  logic [tame_pkg::POS_W-1:0]           target_azimuth_steps,
    input  logic signed [tame_pkg::POS_W-1:0]    target_altitude_steps,
    input  logic                                 move_forward,
    input  logic                                 move_start,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tame_pkg::POS_W-1:0]           azimuth_position,
    output logic signed [tame_pkg::POS_W-1:0]    altitude_position,
    output logic [1:0]                           azimuth_mode,
    output logic [1:0]                           altitude_mode,
    output logic                                 goto_busy
);

    localparam int AZ_W      = tame_pkg::AZ_W;
    localparam int POS_W     = tame_pkg::POS_W;
    localparam int STEP_W    = tame_pkg::STEP_W;
    localparam int ALT_SUM_W = tame_pkg::ALT_SUM_W;
    localparam int DIST_W    = tame_pkg::DIST_W;

    logic [tame_pkg::RATE_W-1:0] slew_rate_reg;

    // Command stage.
    logic                          s1_valid_reg;
    logic [tame_pkg::CMD_W-1:0]    cmd_reg;
    logic [STEP_W-1:0]             steps_reg;
    logic [POS_W-1:0]              tgt_az_reg;
    logic signed [POS_W-1:0]       tgt_alt_reg;
    logic                          fwd_reg;
    logic                          start_reg;

    // Axis state, which doubles as the result word.
    logic                          out_valid_reg;
    logic [AZ_W-1:0]               az_count_reg, az_count_next;
    logic signed [POS_W-1:0]       alt_count_reg, alt_count_next;
    logic [AZ_W-1:0]               az_goal_reg, az_goal_next;
    logic signed [POS_W-1:0]       alt_goal_reg, alt_goal_next;
    tame_pkg::mode_t               az_state_reg, az_state_next;
    tame_pkg::mode_t               alt_state_reg, alt_state_next;
    logic                          az_dir_reg, az_dir_next;
    logic                          alt_dir_reg, alt_dir_next;
    logic                          goto_flag_reg, goto_flag_next;

    logic out_load;
    logic advance;
    logic in_accept;

    // Tick datapath.
    logic                          whole_rev;
    logic [AZ_W-1:0]               az_steps;
    logic [AZ_W-1:0]               az_now;
    logic                          az_found;
    logic [STEP_W-1:0]             alt_delta;
    logic signed [ALT_SUM_W-1:0]   alt_base;
    logic signed [ALT_SUM_W-1:0]   alt_delta_s;
    logic signed [ALT_SUM_W-1:0]   alt_sum;
    logic                          alt_hit_hi;
    logic                          alt_hit_lo;
    logic signed [POS_W-1:0]       alt_clamped;
    logic signed [DIST_W-1:0]      alt_diff;
    logic [DIST_W-1:0]             alt_dist;
    logic                          alt_reached;

    // Goto datapath.
    logic [AZ_W-1:0]               az_goal_in;
    logic signed [POS_W-1:0]       alt_goal_in;
    logic [AZ_W-1:0]               az_fwd_dist;
    logic [AZ_W-1:0]               az_rev_dist;

    assign out_load  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_load;
    assign in_stall  = s1_valid_reg && !out_load;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slew_rate_reg <= tame_pkg::SLEW_RATE_RESET;
        end
        else if (cfg_write)
        begin
            slew_rate_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // User must set the slew rate only when idle (unenforced), so multiply here.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg     <= cmd;
            steps_reg   <= STEP_W'(elapsed_units) * STEP_W'(slew_rate_reg);
            tgt_az_reg  <= target_azimuth_steps;
            tgt_alt_reg <= target_altitude_steps;
            fwd_reg     <= move_forward;
            start_reg   <= move_start;
        end
    end

    // Azimuth tick: one revolution is a power of two, so the step count
    // reduced modulo a revolution is its low bits.
    always_comb
    begin
        whole_rev = |steps_reg[STEP_W-1:AZ_W];
        az_steps  = steps_reg[AZ_W-1:0];
        az_now    = (az_dir_reg == tame_pkg::DIR_FWD) ? az_count_reg + az_steps
                                                      : az_count_reg - az_steps;
        // The goal counts as met if it lies on the arc just swept, ends included.
        if (whole_rev)
        begin
            az_found = 1'b1;
        end
        else if (az_dir_reg == tame_pkg::DIR_FWD)
        begin
            if (az_now < az_count_reg)
            begin
                az_found = (az_goal_reg >= az_count_reg) || (az_goal_reg <= az_now);
            end
            else
            begin
                az_found = (az_goal_reg >= az_count_reg) && (az_goal_reg <= az_now);
            end
        end
        else
        begin
            if (az_now > az_count_reg)
            begin
                az_found = (az_goal_reg <= az_count_reg) || (az_goal_reg >= az_now);
            end
            else
            begin
                az_found = (az_goal_reg >= az_now) && (az_goal_reg <= az_count_reg);
            end
        end
    end

    // Altitude tick: free slewing moves by the reduced count, slewing to a
    // target moves by the full count. Both clamp at the limits.
    always_comb
    begin
        alt_delta   = (alt_state_reg == tame_pkg::MODE_SLEW) ? STEP_W'(az_steps) : steps_reg;
        alt_base    = ALT_SUM_W'(alt_count_reg);
        alt_delta_s = signed'({2'b00, alt_delta});
        alt_sum     = (alt_dir_reg == tame_pkg::DIR_FWD) ? alt_base + alt_delta_s
                                                         : alt_base - alt_delta_s;
        alt_hit_hi  = alt_sum > tame_pkg::ALT_SUM_MAX;
        alt_hit_lo  = alt_sum < tame_pkg::ALT_SUM_MIN;
        if (alt_hit_hi)
        begin
            alt_clamped = tame_pkg::ALT_MAX;
        end
        else if (alt_hit_lo)
        begin
            alt_clamped = tame_pkg::ALT_MIN;
        end
        else
        begin
            alt_clamped = alt_sum[POS_W-1:0];
        end
        alt_diff    = DIST_W'(alt_goal_reg) - DIST_W'(alt_count_reg);
        alt_dist    = (alt_diff < 0) ? DIST_W'(-alt_diff) : DIST_W'(alt_diff);
        alt_reached = STEP_W'(alt_dist) <= steps_reg;
    end

    // Goto targets: the azimuth target already lies within one revolution.
    always_comb
    begin
        az_goal_in = tgt_az_reg[AZ_W-1:0];
        if (tgt_alt_reg > tame_pkg::ALT_MAX)
        begin
            alt_goal_in = tame_pkg::ALT_MAX;
        end
        else if (tgt_alt_reg < tame_pkg::ALT_MIN)
        begin
            alt_goal_in = tame_pkg::ALT_MIN;
        end
        else
        begin
            alt_goal_in = tgt_alt_reg;
        end
        az_fwd_dist = az_goal_in - az_count_reg;
        az_rev_dist = az_count_reg - az_goal_in;
    end

    always_comb
    begin
        az_count_next  = az_count_reg;
        alt_count_next = alt_count_reg;
        az_goal_next   = az_goal_reg;
        alt_goal_next  = alt_goal_reg;
        az_state_next  = az_state_reg;
        alt_state_next = alt_state_reg;
        az_dir_next    = az_dir_reg;
        alt_dir_next   = alt_dir_reg;
        goto_flag_next = goto_flag_reg;
        case (cmd_reg)
            tame_pkg::CMD_TICK:
            begin
                if (az_state_reg == tame_pkg::MODE_SLEW)
                begin
                    az_count_next = az_now;
                end
                else if (az_state_reg == tame_pkg::MODE_SLEW_TO)
                begin
                    if (az_found)
                    begin
                        az_count_next = az_goal_reg;
                        az_state_next = tame_pkg::MODE_STOPPED;
                    end
                    else
                    begin
                        az_count_next = az_now;
                    end
                end
                if (alt_state_reg == tame_pkg::MODE_SLEW_TO && alt_reached)
                begin
                    alt_count_next = alt_goal_reg;
                    alt_state_next = tame_pkg::MODE_STOPPED;
                end
                else if (alt_state_reg == tame_pkg::MODE_SLEW
                         || alt_state_reg == tame_pkg::MODE_SLEW_TO)
                begin
                    alt_count_next = alt_clamped;
                    if (alt_hit_hi || alt_hit_lo)
                    begin
                        alt_state_next = tame_pkg::MODE_STOPPED;
                    end
                end
                if (az_state_next == tame_pkg::MODE_STOPPED
                    && alt_state_next == tame_pkg::MODE_STOPPED)
                begin
                    goto_flag_next = 1'b0;
                end
            end
            tame_pkg::CMD_GOTO:
            begin
                az_goal_next  = az_goal_in;
                alt_goal_next = alt_goal_in;
                if (alt_goal_in == alt_count_reg)
                begin
                    alt_state_next = tame_pkg::MODE_STOPPED;
                end
                else
                begin
                    alt_dir_next   = (alt_goal_in > alt_count_reg) ? tame_pkg::DIR_FWD
                                                                   : tame_pkg::DIR_REV;
                    alt_state_next = tame_pkg::MODE_SLEW_TO;
                end
                // Take the shorter way round; an exact half turn goes in reverse
                // from below and forward from above.
                if (az_goal_in == az_count_reg)
                begin
                    az_state_next = tame_pkg::MODE_STOPPED;
                end
                else
                begin
                    if (az_goal_in > az_count_reg)
                    begin
                        az_dir_next = (az_fwd_dist < tame_pkg::HALF_REV) ? tame_pkg::DIR_FWD
                                                                         : tame_pkg::DIR_REV;
                    end
                    else
                    begin
                        az_dir_next = (az_rev_dist < tame_pkg::HALF_REV) ? tame_pkg::DIR_REV
                                                                         : tame_pkg::DIR_FWD;
                    end
                    az_state_next = tame_pkg::MODE_SLEW_TO;
                end
                goto_flag_next = 1'b1;
            end
            tame_pkg::CMD_MOVE_ALT:
            begin
                alt_dir_next   = fwd_reg;
                alt_state_next = start_reg ? tame_pkg::MODE_SLEW : tame_pkg::MODE_STOPPED;
            end
            tame_pkg::CMD_MOVE_AZ:
            begin
                az_dir_next   = fwd_reg;
                az_state_next = start_reg ? tame_pkg::MODE_SLEW : tame_pkg::MODE_STOPPED;
            end
            tame_pkg::CMD_ABORT:
            begin
                az_state_next  = tame_pkg::MODE_STOPPED;
                alt_state_next = tame_pkg::MODE_STOPPED;
                goto_flag_next = 1'b0;
            end
            default:
            begin
                goto_flag_next = goto_flag_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            az_count_reg  <= '0;
            alt_count_reg <= '0;
            az_goal_reg   <= '0;
            alt_goal_reg  <= '0;
            az_state_reg  <= tame_pkg::MODE_STOPPED;
            alt_state_reg <= tame_pkg::MODE_STOPPED;
            az_dir_reg    <= tame_pkg::DIR_FWD;
            alt_dir_reg   <= tame_pkg::DIR_FWD;
            goto_flag_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= advance;
            end
            if (advance)
            begin
                az_count_reg  <= az_count_next;
                alt_count_reg <= alt_count_next;
                az_goal_reg   <= az_goal_next;
                alt_goal_reg  <= alt_goal_next;
                az_state_reg  <= az_state_next;
                alt_state_reg <= alt_state_next;
                az_dir_reg    <= az_dir_next;
                alt_dir_reg   <= alt_dir_next;
                goto_flag_reg <= goto_flag_next;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign azimuth_position  = POS_W'(az_count_reg);
    assign altitude_position = alt_count_reg;
    assign azimuth_mode      = az_state_reg;
    assign altitude_mode     = alt_state_reg;
    assign goto_busy         = goto_flag_reg;

`ifndef SYNTH
    // The altitude axis never leaves its travel range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (alt_count_reg <= tame_pkg::ALT_MAX) && (alt_count_reg >= tame_pkg::ALT_MIN))
        else $error("altitude count outside its limits");

    // An abort leaves both axes stopped and the goto flag clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg == tame_pkg::CMD_ABORT) |=>
        (az_state_reg == tame_pkg::MODE_STOPPED && alt_state_reg == tame_pkg::MODE_STOPPED
         && !goto_flag_reg && out_valid_reg))
        else $error("abort did not stop the mount");

    // A tick that stops both axes ends any goto.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg == tame_pkg::CMD_TICK
         && az_state_next == tame_pkg::MODE_STOPPED
         && alt_state_next == tame_pkg::MODE_STOPPED) |=> !goto_flag_reg)
        else $error("goto flag left set with both axes stopped");

    // An empty command stage never holds off the sender.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with an empty command stage");
`endif

endmodule

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tame_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SHOWN_LIMIT   = 10;
    localparam int SCRIPT_ROWS   = 25;

    // Highest code of the command field; codes above CMD_ABORT do nothing.
    localparam logic [CMD_W-1:0] CMD_UNUSED_TOP = '1;

    typedef struct packed {
        logic [CMD_W-1:0]        op;
        logic [ELAPSED_W-1:0]    elapsed;
        logic [POS_W-1:0]        az_target;
        logic signed [POS_W-1:0] alt_target;
        logic                    fwd;
        logic                    start;
    } mount_cmd_t;

    typedef struct packed {
        logic [POS_W-1:0]        az_pos;
        logic signed [POS_W-1:0] alt_pos;
        mode_t                   az_mode;
        mode_t                   alt_mode;
        logic                    busy;
    } mount_pos_t;

    typedef struct {
        mount_cmd_t c;
        logic       typed;
        mount_pos_t want;
    } script_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [RATE_W-1:0]       cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [CMD_W-1:0]        cmd;
    logic [ELAPSED_W-1:0]    elapsed_units;
    logic [POS_W-1:0]        target_azimuth_steps;
    logic signed [POS_W-1:0] target_altitude_steps;
    logic                    move_forward;
    logic                    move_start;
    logic                    out_valid;
    logic                    out_stall;
    logic [POS_W-1:0]        azimuth_position;
    logic signed [POS_W-1:0] altitude_position;
    logic [1:0]              azimuth_mode;
    logic [1:0]              altitude_mode;
    logic                    goto_busy;

    // Mirror of the mount state.
    logic [RATE_W-1:0] step_rate;
    logic [AZ_W-1:0]   az_at;
    logic [AZ_W-1:0]   az_aim;
    longint            alt_at;
    longint            alt_aim;
    mode_t             az_mode_now;
    mode_t             alt_mode_now;
    logic              az_heading;
    logic              alt_heading;
    logic              goto_pending;

    mount_pos_t pending_positions [$];
    int         error_count;
    int         cycle_count;
    int         sender_gap_pct;
    int         stall_pct;
    int         hold_request;
    int         hold_left;

    script_row_t script [0:SCRIPT_ROWS-1] = '{
        '{'{CMD_TICK, 0, 0, 0, 0, 0}, 1'b1,
          '{0, 0, MODE_STOPPED, MODE_STOPPED, 1'b0}},
        '{'{CMD_ABORT, 0, 0, 0, 0, 0}, 1'b1,
          '{0, 0, MODE_STOPPED, MODE_STOPPED, 1'b0}},
        '{'{CMD_UNUSED_TOP, 65535, 2097151, -1, 1, 1}, 1'b1,
          '{0, 0, MODE_STOPPED, MODE_STOPPED, 1'b0}},
        '{'{CMD_GOTO, 0, 0, 0, 0, 0}, 1'b1,
          '{0, 0, MODE_STOPPED, MODE_STOPPED, 1'b1}},
        '{'{CMD_TICK, 65535, 0, 0, 0, 0}, 1'b1,
          '{0, 0, MODE_STOPPED, MODE_STOPPED, 1'b0}},
        '{'{CMD_GOTO, 0, 1024, 1024, 0, 0}, 1'b1,
          '{0, 0, MODE_SLEW_TO, MODE_SLEW_TO, 1'b1}},
        // One tick of 1024 steps lands exactly on both targets.
        '{'{CMD_TICK, 1, 0, 0, 0, 0}, 1'b1,
          '{1024, 1024, MODE_STOPPED, MODE_STOPPED, 1'b0}},
        // Azimuth target exactly half a revolution away; altitude target past the limit.
        '{'{CMD_GOTO, 0, 1049600, 1048575, 0, 0}, 1'b0, '0},
        '{'{CMD_TICK, 65535, 0, 0, 0, 0}, 1'b0, '0},
        '{'{CMD_GOTO, 0, 0, -1048576, 0, 0}, 1'b0, '0},
        '{'{CMD_TICK, 100, 0, 0, 0, 0}, 1'b0, '0},
        '{'{CMD_ABORT, 0, 0, 0, 0, 0}, 1'b0, '0},
        '{'{CMD_MOVE_ALT, 0, 0, 0, 1, 1}, 1'b0, '0},
        '{'{CMD_TICK, 65535, 0, 0, 0, 0}, 1'b0, '0},
        '{'{CMD_MOVE_ALT, 0, 0, 0, 0, 1}, 1'b0, '0},
        '{'{CMD_TICK, 65535, 0, 0, 0, 0}, 1'b0, '0},
        '{'{CMD_MOVE_AZ, 0, 0, 0, 0, 1}, 1'b0, '0},
        '{'{CMD_TICK, 2, 0, 0, 0, 0}, 1'b0, '0},
        '{'{CMD_MOVE_AZ, 0, 0, 0, 1, 1}, 1'b0, '0},
        '{'{CMD_TICK, 65535, 0, 0, 0, 0}, 1'b0, '0},
        '{'{CMD_MOVE_AZ, 0, 0, 0, 1, 0}, 1'b0, '0},
        '{'{CMD_TICK, 5, 0, 0, 0, 0}, 1'b0, '0},
        '{'{CMD_GOTO, 0, 2097151, 0, 0, 0}, 1'b0, '0},
        '{'{CMD_TICK, 1, 0, 0, 0, 0}, 1'b0, '0},
        '{'{CMD_ABORT, 0, 0, 0, 0, 0}, 1'b0, '0}
    };

    two_axis_mount_encoder_stepper_top u_top (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_write             (cfg_write),
        .cfg_data              (cfg_data),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .cmd                   (cmd),
        .elapsed_units         (elapsed_units),
        .target_azimuth_steps  (target_azimuth_steps),
        .target_altitude_steps (target_altitude_steps),
        .move_forward          (move_forward),
        .move_start            (move_start),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .azimuth_position      (azimuth_position),
        .altitude_position     (altitude_position),
        .azimuth_mode          (azimuth_mode),
        .altitude_mode         (altitude_mode),
        .goto_busy             (goto_busy)
    );

    initial clk = 1'b0;

    always #1 clk = ~clk;

    function automatic longint clamp_alt(input longint v, output logic hit);
        hit = 1'b1;
        if (v > ALT_LIMIT)
            return ALT_LIMIT;
        if (v < -ALT_LIMIT)
            return -ALT_LIMIT;
        hit = 1'b0;
        return v;
    endfunction

    // Applies one command word to the mirrored state and returns the positions it reports.
    function automatic mount_pos_t advance_mount(input mount_cmd_t c);
        logic [STEP_W-1:0] steps;
        logic [AZ_W-1:0]   arc;
        logic [AZ_W-1:0]   prev;
        logic [AZ_W-1:0]   now;
        logic              whole;
        logic              found;
        logic              hit;
        longint            alt_gap;
        longint            reach;
        mount_pos_t        r;

        case (c.op)
            CMD_TICK:
            begin
                steps = STEP_W'(c.elapsed) * STEP_W'(step_rate);
                whole = (steps >> AZ_W) != 0;
                arc   = steps[AZ_W-1:0];
                if (az_mode_now != MODE_STOPPED)
                begin
                    prev = az_at;
                    now  = (az_heading == DIR_FWD) ? prev + arc : prev - arc;
                    if (az_mode_now == MODE_SLEW)
                        az_at = now;
                    else
                    begin
                        // The swept arc includes both ends and may wrap past zero.
                        if (whole)
                            found = 1'b1;
                        else if (az_heading == DIR_FWD)
                            found = (now < prev) ? (az_aim >= prev || az_aim <= now)
                                                 : (az_aim >= prev && az_aim <= now);
                        else
                            found = (now > prev) ? (az_aim <= prev || az_aim >= now)
                                                 : (az_aim >= now && az_aim <= prev);
                        if (found)
                        begin
                            az_at       = az_aim;
                            az_mode_now = MODE_STOPPED;
                        end
                        else
                            az_at = now;
                    end
                end
                if (alt_mode_now != MODE_STOPPED)
                begin
                    alt_gap = alt_aim - alt_at;
                    if (alt_gap < 0)
                        alt_gap = -alt_gap;
                    if (alt_mode_now == MODE_SLEW_TO && alt_gap <= longint'(steps))
                    begin
                        alt_at       = alt_aim;
                        alt_mode_now = MODE_STOPPED;
                    end
                    else
                    begin
                        // Free slewing moves by the reduced count, a goto by the full one.
                        if (alt_mode_now == MODE_SLEW)
                            reach = longint'(arc);
                        else
                            reach = longint'(steps);
                        alt_at = clamp_alt(alt_at + ((alt_heading == DIR_FWD) ? reach : -reach),
                                           hit);
                        if (hit)
                            alt_mode_now = MODE_STOPPED;
                    end
                end
                if (az_mode_now == MODE_STOPPED && alt_mode_now == MODE_STOPPED)
                    goto_pending = 1'b0;
            end
            CMD_GOTO:
            begin
                alt_aim = clamp_alt(longint'($signed(c.alt_target)), hit);
                az_aim  = c.az_target;
                if (alt_aim == alt_at)
                    alt_mode_now = MODE_STOPPED;
                else
                begin
                    alt_heading  = (alt_aim > alt_at) ? DIR_FWD : DIR_REV;
                    alt_mode_now = MODE_SLEW_TO;
                end
                if (az_aim == az_at)
                    az_mode_now = MODE_STOPPED;
                else
                begin
                    // Shorter way round; an exact half revolution goes in reverse when the
                    // target is above the count and forward when it is below.
                    if (az_aim > az_at)
                        az_heading = (az_aim - az_at < HALF_REV) ? DIR_FWD : DIR_REV;
                    else
                        az_heading = (az_at - az_aim < HALF_REV) ? DIR_REV : DIR_FWD;
                    az_mode_now = MODE_SLEW_TO;
                end
                goto_pending = 1'b1;
            end
            CMD_MOVE_ALT:
            begin
                alt_heading = c.fwd;
                if (c.start)
                    alt_mode_now = MODE_SLEW;
                else
                    alt_mode_now = MODE_STOPPED;
            end
            CMD_MOVE_AZ:
            begin
                az_heading = c.fwd;
                if (c.start)
                    az_mode_now = MODE_SLEW;
                else
                    az_mode_now = MODE_STOPPED;
            end
            CMD_ABORT:
            begin
                az_mode_now  = MODE_STOPPED;
                alt_mode_now = MODE_STOPPED;
                goto_pending = 1'b0;
            end
            default:
            begin
            end
        endcase

        r.az_pos   = az_at;
        r.alt_pos  = POS_W'(alt_at);
        r.az_mode  = az_mode_now;
        r.alt_mode = alt_mode_now;
        r.busy     = goto_pending;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= SHOWN_LIMIT)
            $display("%s", msg);
    endtask

    task automatic send_word(input mount_cmd_t c, input logic typed, input mount_pos_t want);
        mount_pos_t predicted;

        @(negedge clk);
        while (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid              <= 1'b1;
        cmd                   <= c.op;
        elapsed_units         <= c.elapsed;
        target_azimuth_steps  <= c.az_target;
        target_altitude_steps <= c.alt_target;
        move_forward          <= c.fwd;
        move_start            <= c.start;
        do
            @(posedge clk);
        while (in_stall);
        predicted = advance_mount(c);
        pending_positions.insert(pending_positions.size(), typed ? want : predicted);
    endtask

    // Lowers valid and waits until every word sent has come back.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_positions.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic [RATE_W-1:0] rate, input int gap, input int stall,
                             input int hold, input int count);
        mount_cmd_t c;
        int         roll;
        int         pick;

        settle();
        cfg_write <= 1'b1;
        cfg_data  <= rate;
        @(negedge clk);
        cfg_write <= 1'b0;
        step_rate = rate;
        sender_gap_pct = gap;
        stall_pct      = stall;
        hold_request   = hold;

        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(9);
            if (pick < 7)
                c.elapsed = ELAPSED_W'($urandom_range(63));
            else if (pick < 9)
                c.elapsed = ELAPSED_W'($urandom_range(4095));
            else
                c.elapsed = ELAPSED_W'($urandom());
            if ($urandom_range(1))
            begin
                c.az_target  = POS_W'($urandom());
                c.alt_target = POS_W'($urandom());
            end
            else
            begin
                // Targets near the current azimuth and inside the altitude range.
                c.az_target  = az_at + POS_W'($urandom_range(8191)) - POS_W'(4096);
                c.alt_target = POS_W'($urandom_range(2 * ALT_LIMIT)) - POS_W'(ALT_LIMIT);
            end
            c.fwd   = 1'($urandom_range(1));
            c.start = 1'($urandom_range(1));
            roll = $urandom_range(99);
            if (roll < 58)
                c.op = CMD_TICK;
            else if (roll < 72)
                c.op = CMD_GOTO;
            else if (roll < 81)
                c.op = CMD_MOVE_ALT;
            else if (roll < 90)
                c.op = CMD_MOVE_AZ;
            else if (roll < 95)
                c.op = CMD_ABORT;
            else
                c.op = CMD_W'($urandom_range(CMD_ABORT + 1, CMD_UNUSED_TOP));
            send_word(c, 1'b0, '0);
        end
    endtask

    // Receiver side: random stalls, or a long hold-off when one is requested.
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= (stall_pct > 0 && $urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_words
        mount_pos_t got;
        mount_pos_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            got.az_pos   = azimuth_position;
            got.alt_pos  = altitude_position;
            got.az_mode  = mode_t'(azimuth_mode);
            got.alt_mode = mode_t'(altitude_mode);
            got.busy     = goto_busy;
            if (pending_positions.size() == 0)
                note_failure($sformatf("unexpected word: az %0d alt %0d", got.az_pos,
                                       got.alt_pos));
            else
            begin
                want = pending_positions.pop_front();
                if (got.az_pos !== want.az_pos || got.alt_pos !== want.alt_pos
                    || got.az_mode !== want.az_mode || got.alt_mode !== want.alt_mode
                    || got.busy !== want.busy)
                    note_failure($sformatf(
                        "exp/act az %0d/%0d alt %0d/%0d mode %0d/%0d %0d/%0d busy %0d/%0d",
                        want.az_pos, got.az_pos, want.alt_pos, got.alt_pos,
                        want.az_mode, got.az_mode, want.alt_mode, got.alt_mode,
                        want.busy, got.busy));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_write             = 1'b0;
        cfg_data              = '0;
        in_valid              = 1'b0;
        cmd                   = CMD_TICK;
        elapsed_units         = '0;
        target_azimuth_steps  = '0;
        target_altitude_steps = '0;
        move_forward          = 1'b0;
        move_start            = 1'b0;
        error_count           = 0;
        cycle_count           = 0;
        sender_gap_pct        = 0;
        stall_pct             = 0;
        hold_request          = 0;

        step_rate    = SLEW_RATE_RESET;
        az_at        = '0;
        az_aim       = '0;
        alt_at       = 0;
        alt_aim      = 0;
        az_mode_now  = MODE_STOPPED;
        alt_mode_now = MODE_STOPPED;
        az_heading   = DIR_FWD;
        alt_heading  = DIR_FWD;
        goto_pending = 1'b0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < SCRIPT_ROWS; i++)
            send_word(script[i].c, script[i].typed, script[i].want);

        run_phase(16'hFFFF, 0, 0, 0, 250);
        run_phase(16'h0000, 51, 0, 0, 150);
        run_phase(16'h0001, 0, 51, 0, 250);
        run_phase(RATE_W'($urandom_range(1, 8191)), 34, 34, 0, 300);
        // The receiver holds off long enough for the block to stall its input.
        run_phase(RATE_W'($urandom_range(1, 65535)), 0, 0, 400, 250);
        run_phase(RATE_W'($urandom_range(1, 4095)), 34, 34, 0, 300);
        settle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
rtl/tame_pkg.sv
rtl/two_axis_mount_encoder_stepper_top.sv
tb/testbench.sv
